// ===== rtl/and_mul_coefficient_splitter_core_assert.svh =====
// Assertion macros for the coefficient splitter
`ifndef AND_MUL_COEFFICIENT_SPLITTER_CORE_ASSERT_SVH
`define AND_MUL_COEFFICIENT_SPLITTER_CORE_ASSERT_SVH
// assert that a implies b on the next edge
`define AMCS_ASSERT_NEXT(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// assert that a implies b on the same edge
`define AMCS_ASSERT_SAME(label, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

// ===== rtl/amcs_pkg.sv =====
// Shared types and constants of the coefficient splitter
package amcs_pkg;
    localparam int MAX_VARS_DEF = 6;
    localparam int DW = 64;
    localparam logic OP_MASK = 1'b0;
    localparam logic OP_SINGLE = 1'b1;
    localparam logic [1:0] CFG_VAR_COUNT = 2'd0;
    localparam logic [1:0] CFG_BIT_WIDTH = 2'd1;
    localparam logic [1:0] CFG_SINGLETONS = 2'd2;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_INV_INIT,
        CMD_INV_MUL_A,
        CMD_INV_MUL_B,
        CMD_INV_STEP,
        CMD_INV_STORE,
        CMD_G_INIT,
        CMD_G_RD,
        CMD_G_ACC,
        CMD_SOLVE_MUL,
        CMD_SOLVE_WR,
        CMD_OUT_RD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [5:0] m;
        logic [5:0] s;
        logic [2:0] deg;
    } cmd_t;

    typedef struct packed {
        logic diff_zero;
        logic coeff_zero;
        logic mul_done;
    } stat_t;

    function automatic logic [2:0] pop6(input logic [5:0] v);
        logic [2:0] c;
        c = '0;
        for (int i = 0; i < 6; i++) c = c + {2'b0, v[i]};
        return c;
    endfunction

    function automatic logic [63:0] wmask(input logic [6:0] w);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 64; i++) r[i] = (i < int'(w));
        return r;
    endfunction
endpackage

// ===== rtl/and_mul_coefficient_splitter_core.sv =====
// Top level of the coefficient splitter
// Load beats are taken one per cycle. The beat with last set starts a run
// during which no load beat and no register write is taken: it clears each
// store entry (64 at the default depth), builds the inverse for each degree,
// then per popcount pass scans every mask and closes the pass.
// A mask with a zero coefficient is skipped after its coefficient read, a
// mask with a zero difference after its submask walk; a solved mask also
// takes a multiply and a store write. Each result beat waits on any stall.
// The single-port stores and one shared 32 by 32 multiplier set this pace.
module and_mul_coefficient_splitter_core #(
    parameter int MAX_VARS = amcs_pkg::MAX_VARS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [5:0]  index,
    input  logic [63:0] coeff_value,
    input  logic [63:0] eval_value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  mask,
    output logic [63:0] and_coeff,
    output logic [63:0] mul_coeff,
    output logic        final_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    import amcs_pkg::*;
    `include "and_mul_coefficient_splitter_core_assert.svh"

    localparam int NVL = (MAX_VARS < 6) ? MAX_VARS : 6;

    logic [2:0] var_count_reg;
    logic [6:0] bit_width_reg;
    logic       single_reg;
    logic [2:0] n;
    logic [6:0] w;
    logic       busy, acc;
    cmd_t       cmd;
    stat_t      stat;

    assign cfg_ready = !busy;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            var_count_reg <= 3'd6;
            bit_width_reg <= 7'd64;
            single_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_VAR_COUNT:  var_count_reg <= cfg_data[2:0];
                CFG_BIT_WIDTH:  bit_width_reg <= cfg_data[6:0];
                CFG_SINGLETONS: single_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign n = (var_count_reg > 3'(NVL)) ? 3'(NVL) : var_count_reg;
    assign w = (bit_width_reg < 7'd2) ? 7'd2 : ((bit_width_reg > 7'd64) ? 7'd64 : bit_width_reg);
    assign in_stall = busy;
    assign acc = in_valid && !busy;

    amcs_ctrl #(.MAX_VARS(MAX_VARS)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(acc && last), .n(n), .single(single_reg),
        .stat(stat), .out_stall(out_stall), .cmd(cmd), .busy(busy),
        .out_valid(out_valid), .out_mask(mask), .out_final(final_res)
    );

    amcs_dp #(.MAX_VARS(MAX_VARS)) u_dp (
        .clk(clk), .rst_n(rst_n), .ld_en(acc), .op(op), .index(index),
        .coeff_value(coeff_value), .eval_value(eval_value), .w(w),
        .single(single_reg), .cmd(cmd), .stat(stat),
        .and_coeff(and_coeff), .mul_coeff(mul_coeff)
    );

    `AMCS_ASSERT_NEXT(a_start_busy, acc && last, busy)
    `AMCS_ASSERT_SAME(a_out_busy, out_valid, busy)
    `AMCS_ASSERT_NEXT(a_final_idle, out_valid && !out_stall && final_res, !busy)
endmodule

// ===== rtl/amcs_ctrl.sv =====
// Run sequencer: store clear, inverse build, popcount walk, submask walk, result drain
module amcs_ctrl #(
    parameter int MAX_VARS = amcs_pkg::MAX_VARS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2:0]     n,
    input  logic           single,
    input  amcs_pkg::stat_t stat,
    input  logic           out_stall,
    output amcs_pkg::cmd_t cmd,
    output logic           busy,
    output logic           out_valid,
    output logic [5:0]     out_mask,
    output logic           out_final
);
    import amcs_pkg::*;

    localparam int NVL = (MAX_VARS < 6) ? MAX_VARS : 6;
    localparam int CLR_LAST = (1 << NVL) - 1;

    typedef enum logic [4:0] {
        S_IDLE, S_CLEAR, S_INV, S_IMA, S_IWA, S_IMB, S_IWB, S_ISTEP, S_INVS,
        S_NEXTM, S_RDC, S_GINIT, S_GRD, S_GACC, S_MUL, S_MWAIT, S_WR,
        S_ORD, S_OWAIT, S_OUT
    } state_t;

    state_t     state_reg;
    logic [6:0] m_reg;
    logic [5:0] s_reg;
    logic [2:0] k_reg, deg_reg, it_reg;
    logic       fin_reg;
    logic [6:0] len;
    logic [2:0] maxdeg;

    assign len = 7'd1 << n;
    assign maxdeg = (n < 3'd2) ? 3'd2 : n;
    assign busy = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_mask = m_reg[5:0];
    assign out_final = fin_reg;

    always_comb
    begin
        cmd = '{op: CMD_NONE, m: m_reg[5:0], s: s_reg, deg: deg_reg};
        case (state_reg)
            S_CLEAR: cmd.op = CMD_CLEAR;
            S_INV:   cmd.op = CMD_INV_INIT;
            S_IMA:   cmd.op = CMD_INV_MUL_A;
            S_IMB:   cmd.op = CMD_INV_MUL_B;
            S_ISTEP: cmd.op = CMD_INV_STEP;
            S_INVS:  cmd.op = CMD_INV_STORE;
            S_GINIT: cmd.op = CMD_G_INIT;
            S_GRD:   cmd.op = CMD_G_RD;
            S_GACC:  cmd.op = CMD_G_ACC;
            S_MUL:   cmd.op = CMD_SOLVE_MUL;
            S_WR:    cmd.op = CMD_SOLVE_WR;
            S_ORD:   cmd.op = CMD_OUT_RD;
            S_RDC:   cmd.op = CMD_G_RD;
            default: cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_reg <= '0;
            s_reg <= '0;
            k_reg <= '0;
            deg_reg <= '0;
            it_reg <= '0;
            fin_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_CLEAR;
                        m_reg <= '0;
                    end
                end
                S_CLEAR:
                begin
                    m_reg <= m_reg + 7'd1;
                    if (m_reg == 7'(CLR_LAST))
                    begin
                        state_reg <= S_INV;
                        deg_reg <= 3'd2;
                        it_reg <= '0;
                    end
                end
                S_INV:
                begin
                    it_reg <= '0;
                    state_reg <= S_IMA;
                end
                S_IMA: state_reg <= S_IWA;
                S_IWA:
                begin
                    if (stat.mul_done) state_reg <= S_IMB;
                end
                S_IMB: state_reg <= S_IWB;
                S_IWB:
                begin
                    if (stat.mul_done) state_reg <= S_ISTEP;
                end
                S_ISTEP:
                begin
                    it_reg <= it_reg + 3'd1;
                    state_reg <= (it_reg == 3'd4) ? S_INVS : S_IMA;
                end
                S_INVS:
                begin
                    it_reg <= '0;
                    if (deg_reg >= maxdeg)
                    begin
                        k_reg <= 3'd1;
                        m_reg <= '0;
                        state_reg <= (n == 3'd0) ? S_ORD : S_NEXTM;
                    end
                    else
                    begin
                        deg_reg <= deg_reg + 3'd1;
                        state_reg <= S_INV;
                    end
                end
                S_NEXTM:
                begin
                    if (m_reg >= len)
                    begin
                        m_reg <= '0;
                        if (k_reg >= n) state_reg <= S_ORD;
                        else k_reg <= k_reg + 3'd1;
                    end
                    else if (pop6(m_reg[5:0]) != k_reg || (k_reg == 3'd1 && single))
                        m_reg <= m_reg + 7'd1;
                    else
                    begin
                        s_reg <= m_reg[5:0];
                        deg_reg <= (k_reg < 3'd2) ? 3'd2 : k_reg;
                        state_reg <= S_RDC;
                    end
                end
                S_RDC: state_reg <= S_GINIT;
                S_GINIT:
                begin
                    if (stat.coeff_zero)
                    begin
                        m_reg <= m_reg + 7'd1;
                        state_reg <= S_NEXTM;
                    end
                    else state_reg <= S_GRD;
                end
                S_GRD: state_reg <= S_GACC;
                S_GACC:
                begin
                    s_reg <= (s_reg - 6'd1) & m_reg[5:0];
                    state_reg <= (((s_reg - 6'd1) & m_reg[5:0]) == 6'd0) ? S_MUL : S_GRD;
                end
                S_MUL:
                begin
                    if (stat.diff_zero)
                    begin
                        m_reg <= m_reg + 7'd1;
                        state_reg <= S_NEXTM;
                    end
                    else state_reg <= S_MWAIT;
                end
                S_MWAIT:
                begin
                    if (stat.mul_done) state_reg <= S_WR;
                end
                S_WR:
                begin
                    m_reg <= m_reg + 7'd1;
                    state_reg <= S_NEXTM;
                end
                S_ORD: state_reg <= S_OWAIT;
                S_OWAIT:
                begin
                    fin_reg <= (m_reg == len - 7'd1);
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        if (fin_reg) state_reg <= S_IDLE;
                        else
                        begin
                            m_reg <= m_reg + 7'd1;
                            state_reg <= S_ORD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/amcs_dp.sv =====
// Datapath: stores, inverse iteration, submask accumulator, solver
module amcs_dp #(
    parameter int MAX_VARS = amcs_pkg::MAX_VARS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            ld_en,
    input  logic            op,
    input  logic [5:0]      index,
    input  logic [63:0]     coeff_value,
    input  logic [63:0]     eval_value,
    input  logic [6:0]      w,
    input  logic            single,
    input  amcs_pkg::cmd_t  cmd,
    output amcs_pkg::stat_t stat,
    output logic [63:0]     and_coeff,
    output logic [63:0]     mul_coeff
);
    import amcs_pkg::*;

    localparam int NVL = (MAX_VARS < 6) ? MAX_VARS : 6;
    localparam int DEPTH = 1 << NVL;

    logic [63:0] and_mem [DEPTH];
    logic [63:0] work_mem [DEPTH];
    logic [63:0] mul_mem [DEPTH];
    logic [63:0] eval_mem [DEPTH];
    logic [63:0] sing_reg [6];
    logic [62:0] inv_reg [8];

    logic [63:0] fullm, halfm;
    logic [63:0] and_rd_reg, work_rd_reg, mul_rd_reg, eval_rd_reg;
    logic [63:0] g_reg, diff_reg, inv_x_reg, t_reg;
    logic [2:0]  pc_s;
    logic [63:0] mul_term;
    logic [63:0] sing_v;
    logic [2:0]  lowb;
    logic [63:0] mul_a_reg, mul_b_reg, mul_acc_reg;
    logic [1:0]  mul_ph_reg;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic        mul_go;

    assign fullm = wmask(w);
    assign halfm = wmask(w - 7'd1);

    always_comb
    begin
        lowb = 3'd0;
        for (int i = 5; i >= 0; i--)
            if (cmd.s[i]) lowb = 3'(i);
    end
    assign sing_v = sing_reg[lowb];
    assign pc_s = pop6(cmd.s);
    always_comb
    begin
        logic [3:0] dg;
        dg = (pc_s == 3'd1) ? 4'd2 : {1'b0, pc_s};
        mul_term = ({3'b0, dg} >= w) ? 64'd0 : (mul_rd_reg << dg);
    end

    assign mul_go = cmd.op inside {CMD_INV_MUL_A, CMD_INV_MUL_B, CMD_SOLVE_MUL};

    always_comb
    begin
        case (mul_ph_reg)
            2'd2:
            begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b_reg[63:32];
            end
            2'd3:
            begin
                mul_x = mul_a_reg[63:32];
                mul_y = mul_b_reg[31:0];
            end
            default:
            begin
                mul_x = mul_a_reg[31:0];
                mul_y = mul_b_reg[31:0];
            end
        endcase
        mul_p = 64'(mul_x) * 64'(mul_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_ph_reg <= 2'd0;
            mul_acc_reg <= '0;
        end
        else if (mul_go)
            mul_ph_reg <= 2'd1;
        else
        begin
            case (mul_ph_reg)
                2'd1:
                begin
                    mul_acc_reg <= mul_p;
                    mul_ph_reg <= 2'd2;
                end
                2'd2:
                begin
                    mul_acc_reg <= mul_acc_reg + {mul_p[31:0], 32'b0};
                    mul_ph_reg <= 2'd3;
                end
                2'd3:
                begin
                    mul_acc_reg <= mul_acc_reg + {mul_p[31:0], 32'b0};
                    mul_ph_reg <= 2'd0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_en)
        begin
            if (op == OP_MASK)
            begin
                if (int'(index) < DEPTH)
                begin
                    and_mem[index[NVL-1:0]] <= coeff_value;
                    work_mem[index[NVL-1:0]] <= coeff_value;
                    eval_mem[index[NVL-1:0]] <= eval_value;
                end
            end
            else if (index < 6'(NVL))
                sing_reg[index[2:0]] <= coeff_value;
        end
        case (cmd.op)
            CMD_CLEAR:
            begin
                mul_mem[cmd.m[NVL-1:0]] <= '0;
                work_mem[cmd.m[NVL-1:0]] <= and_mem[cmd.m[NVL-1:0]];
            end
            CMD_INV_INIT:
            begin
                inv_x_reg <= ((64'd1 << (cmd.deg - 3'd1)) - 64'd1);
                t_reg <= ((64'd1 << (cmd.deg - 3'd1)) - 64'd1) & halfm;
            end
            CMD_INV_MUL_A:
            begin
                mul_a_reg <= inv_x_reg;
                mul_b_reg <= t_reg;
            end
            CMD_INV_MUL_B:
            begin
                mul_a_reg <= t_reg;
                mul_b_reg <= 64'd2 - mul_acc_reg;
            end
            CMD_INV_STEP: t_reg <= mul_acc_reg & halfm;
            CMD_INV_STORE: inv_reg[cmd.deg] <= t_reg[62:0];
            CMD_G_RD:
            begin
                and_rd_reg <= and_mem[cmd.s[NVL-1:0]];
                work_rd_reg <= work_mem[cmd.s[NVL-1:0]];
                mul_rd_reg <= mul_mem[cmd.s[NVL-1:0]];
                eval_rd_reg <= eval_mem[cmd.s[NVL-1:0]];
            end
            CMD_G_INIT:
            begin
                g_reg <= work_mem[0] & fullm;
                diff_reg <= eval_rd_reg & fullm;
            end
            CMD_G_ACC:
            begin
                if (pc_s == 3'd1 && single) g_reg <= (g_reg + sing_v) & fullm;
                else g_reg <= (g_reg + {work_rd_reg[62:0], 1'b0} + mul_term) & fullm;
            end
            CMD_SOLVE_MUL:
            begin
                mul_a_reg <= ((diff_reg - g_reg) & fullm) >> 1;
                mul_b_reg <= {1'b0, inv_reg[cmd.deg]};
            end
            CMD_SOLVE_WR:
            begin
                mul_mem[cmd.m[NVL-1:0]] <= mul_acc_reg & halfm;
                work_mem[cmd.m[NVL-1:0]] <= (and_mem[cmd.m[NVL-1:0]]
                                             - (mul_acc_reg & halfm)) & fullm;
            end
            CMD_OUT_RD:
            begin
                work_rd_reg <= work_mem[cmd.m[NVL-1:0]];
                mul_rd_reg <= mul_mem[cmd.m[NVL-1:0]];
            end
            default: ;
        endcase
    end

    logic is_single;
    assign is_single = single && (pop6(cmd.m) == 3'd1);
    assign and_coeff = is_single ? 64'd0 : (work_rd_reg & fullm);
    assign mul_coeff = is_single ? 64'd0 : (mul_rd_reg & halfm);
    assign stat.coeff_zero = (and_rd_reg == 64'd0);
    assign stat.diff_zero = (((diff_reg - g_reg) & fullm) == 64'd0);
    assign stat.mul_done = (mul_ph_reg == 2'd0);
endmodule

// ===== verif/amcs_checker.sv =====
// Checker for the coefficient splitter: watches all channels, predicts results and compares
`timescale 1ns / 100ps
module amcs_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [5:0]  index,
    input  logic [63:0] coeff_value,
    input  logic [63:0] eval_value,
    input  logic        last,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [5:0]  mask,
    input  logic [63:0] and_coeff,
    input  logic [63:0] mul_coeff,
    input  logic        final_res,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    output int          fail_count,
    output int          pending_cnt
);
    import amcs_pkg::*;

    typedef struct {
        logic [5:0]  mask;
        logic [63:0] and_c;
        logic [63:0] mul_c;
        logic        fin;
    } split_t;

    logic [63:0] coeff_mem [64];
    logic [63:0] eval_mem [64];
    logic [63:0] single_mem [6];
    logic [2:0]  var_cnt;
    logic [6:0]  width_cfg;
    logic        single_on;
    split_t      split_q [$];

    function automatic logic [63:0] low_ones(input int w);
        return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
    endfunction

    function automatic int popc(input logic [5:0] v);
        int c;
        c = 0;
        for (int i = 0; i < 6; i++) c += v[i];
        return c;
    endfunction

    function automatic int lowest_set(input logic [5:0] v);
        int i;
        i = 0;
        while (i < 5 && !v[i]) i++;
        return i;
    endfunction

    function automatic logic [63:0] odd_inverse(input logic [63:0] x, input int w);
        logic [63:0] m;
        logic [63:0] inv;
        m = low_ones(w - 1);
        inv = x & m;
        for (int b = 3; b < w - 1; b *= 2)
            inv = (inv * (64'd2 - x * inv)) & m;
        return inv & m;
    endfunction

    task automatic split_all();
        logic [63:0] work [64];
        logic [63:0] mulv [64];
        logic [63:0] inv_tab [7];
        logic [63:0] fullm, halfm, g, diff, mf;
        logic [5:0]  s;
        split_t      r;
        int          n, w, len, pc, dg;
        n = (var_cnt > 6) ? 6 : int'(var_cnt);
        w = (width_cfg < 2) ? 2 : ((width_cfg > 64) ? 64 : int'(width_cfg));
        len = 1 << n;
        fullm = low_ones(w);
        halfm = low_ones(w - 1);
        for (int i = 0; i < 64; i++)
        begin
            work[i] = coeff_mem[i];
            mulv[i] = '0;
        end
        for (int d = 0; d < 7; d++) inv_tab[d] = '0;
        for (int d = 2; d <= ((n < 2) ? 2 : n); d++)
            inv_tab[d] = odd_inverse((64'd1 << (d - 1)) - 64'd1, w);
        for (int k = 1; k <= n; k++)
        begin
            if (k == 1 && single_on) continue;
            for (int m = 0; m < len; m++)
            begin
                if (popc(6'(m)) != k || coeff_mem[m] == 0) continue;
                g = work[0] & fullm;
                s = 6'(m);
                while (s != 0)
                begin
                    pc = popc(s);
                    if (pc == 1 && single_on)
                        g = (g + single_mem[lowest_set(s) % 6]) & fullm;
                    else
                    begin
                        dg = (pc == 1) ? 2 : pc;
                        mf = (dg >= w) ? 64'd0 : (64'd1 << dg);
                        g = (g + 64'd2 * work[s] + mf * mulv[s]) & fullm;
                    end
                    s = (s - 6'd1) & 6'(m);
                end
                diff = ((eval_mem[m] & fullm) - g) & fullm;
                if (diff == 0) continue;
                dg = (k < 2) ? 2 : k;
                mulv[m] = ((diff >> 1) * inv_tab[dg]) & halfm;
                work[m] = (coeff_mem[m] - mulv[m]) & fullm;
            end
        end
        if (single_on)
            for (int k = 0; k < n; k++)
            begin
                work[1 << k] = '0;
                mulv[1 << k] = '0;
            end
        for (int m = 0; m < len; m++)
        begin
            r.mask = 6'(m);
            r.and_c = work[m] & fullm;
            r.mul_c = mulv[m] & halfm;
            r.fin = (m == len - 1);
            split_q.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        split_t e;
        if (!rst_n)
        begin
            var_cnt = 3'd6;
            width_cfg = 7'd64;
            single_on = 1'b0;
            fail_count = 0;
            pending_cnt = 0;
            for (int i = 0; i < 64; i++)
            begin
                coeff_mem[i] = '0;
                eval_mem[i] = '0;
            end
            for (int i = 0; i < 6; i++) single_mem[i] = '0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (split_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat: mask %0d", mask);
                end
                else
                begin
                    e = split_q.pop_front();
                    if (mask !== e.mask || and_coeff !== e.and_c || mul_coeff !== e.mul_c
                        || final_res !== e.fin)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp %0d %h %h %b got %0d %h %h %b",
                                     e.mask, e.and_c, e.mul_c, e.fin,
                                     mask, and_coeff, mul_coeff, final_res);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_VAR_COUNT) var_cnt = cfg_data[2:0];
                else if (cfg_index == CFG_BIT_WIDTH) width_cfg = cfg_data[6:0];
                else if (cfg_index == CFG_SINGLETONS) single_on = cfg_data[0];
            end
            if (in_valid && !in_stall)
            begin
                if (op == OP_MASK)
                begin
                    coeff_mem[index] = coeff_value;
                    eval_mem[index] = eval_value;
                end
                else if (index < 6)
                    single_mem[index] = coeff_value;
                if (last) split_all();
            end
            pending_cnt = split_q.size();
        end
    end
endmodule

// ===== verif/tb.sv =====
// Testbench top for the coefficient splitter: stimulus, stall patterns and verdict
`timescale 1ns / 100ps
module tb;
    import amcs_pkg::*;

    localparam int LIMIT = 5000000;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        op;
    logic [5:0]  index;
    logic [63:0] coeff_value;
    logic [63:0] eval_value;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [5:0]  mask;
    logic [63:0] and_coeff;
    logic [63:0] mul_coeff;
    logic        final_res;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;
    int          fail_count;
    int          pending_cnt;
    int          cycles = 0;
    int          beats_sent;
    int          burst_left;
    int          stall_mode = 0;
    int          mode_left = 0;

    and_mul_coefficient_splitter_core dut (.*);
    amcs_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver stall pattern: calm, random, or heavy stretches
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left <= $urandom_range(20, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 1) == 1);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_beat(input logic o, input logic [5:0] ix, input logic [63:0] cv,
                             input logic [63:0] ev, input logic lst);
        bit ok;
        int gap;
        in_valid <= 1'b1;
        op <= o;
        index <= ix;
        coeff_value <= cv;
        eval_value <= ev;
        last <= lst;
        do
        begin
            @(negedge clk);
            ok = !in_stall;
            @(posedge clk);
        end
        while (!ok);
        beats_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            gap = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 16);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic write_reg(input logic [1:0] ix, input logic [63:0] val);
        bit ok;
        cfg_valid <= 1'b1;
        cfg_index <= ix;
        cfg_data <= val;
        do
        begin
            @(negedge clk);
            ok = cfg_ready;
            @(posedge clk);
        end
        while (!ok);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_wait();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_cnt != 0) @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_sequence();
        int nl;
        logic o;
        logic [5:0] ix;
        nl = $urandom_range(0, 6);
        for (int i = 0; i <= nl; i++)
        begin
            o = ($urandom_range(0, 3) == 0) ? OP_SINGLE : OP_MASK;
            if (o == OP_SINGLE && $urandom_range(0, 4) != 0) ix = 6'($urandom_range(0, 5));
            else ix = 6'($urandom_range(0, 63));
            send_beat(o, ix, pick64(), pick64(), i == nl);
        end
    endtask

    int          vc_set [9] = '{7, 0, 1, 2, 3, 6, 6, 5, 4};
    int          bw_set [9] = '{64, 2, 3, 0, 127, 33, 63, 1, 65};
    int          sg_set [9] = '{0, 0, 1, 1, 0, 1, 0, 1, 1};

    initial
    begin
        int ph;
        rst_n = 1'b0;
        beats_sent = 0;
        burst_left = 4;
        in_valid <= 1'b0;
        op <= OP_MASK;
        index <= '0;
        coeff_value <= '0;
        eval_value <= '0;
        last <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_VAR_COUNT;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill every store entry once, extremes mixed in
        for (int i = 0; i < 6; i++)
            send_beat(OP_SINGLE, 6'(i), (i == 0) ? '1 : pick64(), '0, 1'b0);
        for (int i = 0; i < 64; i++)
            send_beat(OP_MASK, 6'(i), (i == 5) ? '0 : ((i == 63) ? '1 : pick64()),
                      (i == 62) ? '1 : pick64(), i == 63);
        drain_wait();
        send_beat(OP_SINGLE, 6'd63, '1, '1, 1'b1);
        send_beat(OP_SINGLE, 6'd2, '1, '1, 1'b1);
        send_beat(OP_MASK, 6'd3, 64'd7, 64'd7, 1'b1);
        send_beat(OP_MASK, 6'd0, '0, '0, 1'b0);
        send_beat(OP_MASK, 6'd63, '1, '0, 1'b1);
        drain_wait();
        write_reg(CFG_SPARE, pick64());

        ph = 0;
        while (beats_sent < 255)
        begin
            drain_wait();
            if (ph < 9)
            begin
                write_reg(CFG_VAR_COUNT, 64'(vc_set[ph]));
                write_reg(CFG_BIT_WIDTH, 64'(bw_set[ph]));
                write_reg(CFG_SINGLETONS, 64'(sg_set[ph]));
            end
            else
            begin
                write_reg(CFG_VAR_COUNT, {$urandom, $urandom});
                write_reg(CFG_BIT_WIDTH, {$urandom, $urandom});
                write_reg(CFG_SINGLETONS, {$urandom, $urandom});
            end
            ph++;
            repeat ($urandom_range(3, 6)) random_sequence();
        end
        drain_wait();

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
